[rtl/ucmt_pkg.sv]
// ----------------------------------------------------------------------------
// ucmt_pkg
// Shared types and constants of the I/O unit completion timer.
// ----------------------------------------------------------------------------
package ucmt_pkg;

  localparam int MAX_UNITS   = 64;
  localparam int UNITS_W     = $clog2(MAX_UNITS + 1);
  localparam int IDX_W       = $clog2(MAX_UNITS);
  localparam int BLOCK_SHIFT = 9;

  localparam int FUNC_W   = 2;
  localparam int BLOCK_W  = 64;
  localparam int COUNT_W  = 17;
  localparam int TIME_W   = 64;
  localparam int SHIFT_W  = 5;
  localparam int DELAY_W  = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DIGIT_W     = 4;
  localparam int DIG_CNT_W   = 4;
  localparam int FIRST_DIGITS = BLOCK_W / DIGIT_W;
  localparam int CHUNK_DIGITS = (COUNT_W + DIGIT_W - 1) / DIGIT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIT_SIZE_SHIFT   = 3'd0,
    REG_UNITS_IN_USE      = 3'd1,
    REG_READ_SETUP_DELAY  = 3'd2,
    REG_READ_CHUNK_TIME   = 3'd3,
    REG_READ_TAIL_TIME    = 3'd4,
    REG_WRITE_SETUP_DELAY = 3'd5,
    REG_WRITE_CHUNK_TIME  = 3'd6,
    REG_WRITE_TAIL_TIME   = 3'd7
  } cfg_reg_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MODF  = 8'b0000_0010,
    S_SAVEF = 8'b0000_0100,
    S_MODC  = 8'b0000_1000,
    S_BASE  = 8'b0001_0000,
    S_SEED  = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic save_first;
    logic prep;
    logic base;
    logic seed;
    logic write;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic rw_req;
    logic dig_last;
    logic wr_last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/ucmt_if.sv]
// ----------------------------------------------------------------------------
// ucmt_if
// Command and completion channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ucmt_req_if;
  import ucmt_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [BLOCK_W-1:0]  start_block;
  logic [COUNT_W-1:0]  block_count;
  logic [TIME_W-1:0]   start_time;

  modport source (output valid, func, start_block, block_count, start_time, input ready);
  modport sink   (input valid, func, start_block, block_count, start_time, output ready);
endinterface

interface ucmt_rsp_if;
  import ucmt_pkg::*;

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  completion_time;

  modport source (output valid, completion_time, input ready);
  modport sink   (input valid, completion_time, output ready);
endinterface

[rtl/ucmt_ctrl.sv]
// ----------------------------------------------------------------------------
// ucmt_ctrl
// Sequencer that steps the datapath through one command at a time.
// ----------------------------------------------------------------------------
module ucmt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  ucmt_pkg::dp_status_t status_i,
  output ucmt_pkg::dp_cmd_t    cmd_o
);
  import ucmt_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.rw_req ? S_MODF : S_DONE;
        end
      end
      S_MODF: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.dig_last) begin
          state_d = S_SAVEF;
        end
      end
      S_SAVEF: begin
        cmd_o.save_first = 1'b1;
        state_d          = S_MODC;
      end
      S_MODC: begin
        cmd_o.mod_step = 1'b1;
        cmd_o.prep     = 1'b1;
        if (status_i.dig_last) begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = S_SEED;
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        if (status_i.wr_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/ucmt_dpath.sv]
// ----------------------------------------------------------------------------
// ucmt_dpath
// Configuration registers, remainder unit, busy-time memory and output stage.
// ----------------------------------------------------------------------------
module ucmt_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ucmt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ucmt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [ucmt_pkg::FUNC_W-1:0]      func_i,
  input  logic [ucmt_pkg::BLOCK_W-1:0]     start_block_i,
  input  logic [ucmt_pkg::COUNT_W-1:0]     block_count_i,
  input  logic [ucmt_pkg::TIME_W-1:0]      start_time_i,
  input  ucmt_pkg::dp_cmd_t                cmd_i,
  output ucmt_pkg::dp_status_t             status_o,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output logic [ucmt_pkg::TIME_W-1:0]      completion_time_o
);
  import ucmt_pkg::*;

  localparam int SUM_W  = COUNT_W + (31 - BLOCK_SHIFT);
  localparam int PROD_W = COUNT_W + DELAY_W;

  function automatic logic [UNITS_W-1:0] mod_digit(input logic [UNITS_W-1:0] rem,
                                                   input logic [DIGIT_W-1:0] dig,
                                                   input logic [UNITS_W-1:0] div);
    logic [UNITS_W:0] r;
    r = {1'b0, rem};
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r = {r[UNITS_W-1:0], dig[i]};
      if (r >= {1'b0, div}) begin
        r = r - {1'b0, div};
      end
    end
    return r[UNITS_W-1:0];
  endfunction

  logic [SHIFT_W-1:0]  uss_q;
  logic [UNITS_W-1:0]  units_q;
  logic [DELAY_W-1:0]  rd_setup_q, rd_chunk_q, rd_tail_q;
  logic [DELAY_W-1:0]  wr_setup_q, wr_chunk_q, wr_tail_q;

  logic [SHIFT_W-1:0]  sub_shift;
  logic [UNITS_W-1:0]  units_eff;
  logic [SUM_W-1:0]    ceil_mask, ceil_sum;
  logic [COUNT_W-1:0]  chunks_new;

  logic [FUNC_W-1:0]   func_q;
  logic [TIME_W-1:0]   start_time_q;
  logic [DELAY_W-1:0]  setup_q, chunk_q, tail_q;
  logic [COUNT_W-1:0]  chunks_q, kfrom_q, k_q;
  logic                zero_q;
  logic [BLOCK_W-1:0]  x_q;
  logic [UNITS_W-1:0]  rem_q;
  logic [DIG_CNT_W-1:0] dig_q, dig_lim_q;
  logic [IDX_W-1:0]    first_q, u_q;
  logic [TIME_W-1:0]   maxb_q, base_q, t_q, last_q;
  logic [PROD_W-1:0]   prod_q;

  logic [TIME_W-1:0]   mem_q [MAX_UNITS];
  logic [MAX_UNITS-1:0] vld_q;
  logic [TIME_W-1:0]   rd_data_q;
  logic                rd_vld_q;
  logic [TIME_W-1:0]   busy_first;

  logic [UNITS_W-1:0]  u_sum;
  logic [UNITS_W-1:0]  u_next;
  logic                tail_en;
  logic [TIME_W-1:0]   wr_value;

  logic                rsp_valid_q;
  logic [TIME_W-1:0]   rsp_data_q, result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uss_q      <= SHIFT_W'(12);
      units_q    <= UNITS_W'(MAX_UNITS);
      rd_setup_q <= '0;
      rd_chunk_q <= '0;
      rd_tail_q  <= '0;
      wr_setup_q <= '0;
      wr_chunk_q <= '0;
      wr_tail_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UNIT_SIZE_SHIFT:   uss_q      <= cfg_data_i[SHIFT_W-1:0];
        REG_UNITS_IN_USE:      units_q    <= cfg_data_i[UNITS_W-1:0];
        REG_READ_SETUP_DELAY:  rd_setup_q <= cfg_data_i;
        REG_READ_CHUNK_TIME:   rd_chunk_q <= cfg_data_i;
        REG_READ_TAIL_TIME:    rd_tail_q  <= cfg_data_i;
        REG_WRITE_SETUP_DELAY: wr_setup_q <= cfg_data_i;
        REG_WRITE_CHUNK_TIME:  wr_chunk_q <= cfg_data_i;
        REG_WRITE_TAIL_TIME:   wr_tail_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sub_shift = (uss_q < SHIFT_W'(BLOCK_SHIFT)) ? '0 : uss_q - SHIFT_W'(BLOCK_SHIFT);
    if (units_q == '0) begin
      units_eff = UNITS_W'(1);
    end else if (units_q > UNITS_W'(MAX_UNITS)) begin
      units_eff = UNITS_W'(MAX_UNITS);
    end else begin
      units_eff = units_q;
    end
    ceil_mask  = (SUM_W'(1) << sub_shift) - SUM_W'(1);
    ceil_sum   = (SUM_W'(block_count_i) + ceil_mask) >> sub_shift;
    chunks_new = (block_count_i == '0) ? COUNT_W'(1) : ceil_sum[COUNT_W-1:0];
  end

  assign busy_first = rd_vld_q ? rd_data_q : '0;
  assign u_sum      = UNITS_W'(first_q) + rem_q;
  assign u_next     = UNITS_W'(u_q) + UNITS_W'(1);
  assign tail_en    = !zero_q && (k_q < COUNT_W'(units_eff));
  assign wr_value   = t_q + (tail_en ? TIME_W'(tail_q) : '0);

  // Command registers, remainder unit and busy-time sequencing.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= func_i;
      start_time_q <= start_time_i;
      if (func_i == FUNC_WRITE) begin
        setup_q <= wr_setup_q;
        chunk_q <= wr_chunk_q;
        tail_q  <= wr_tail_q;
      end else begin
        setup_q <= rd_setup_q;
        chunk_q <= rd_chunk_q;
        tail_q  <= rd_tail_q;
      end
      chunks_q  <= chunks_new;
      zero_q    <= (block_count_i == '0);
      x_q       <= start_block_i >> sub_shift;
      rem_q     <= '0;
      dig_q     <= '0;
      dig_lim_q <= DIG_CNT_W'(FIRST_DIGITS - 1);
    end
    if (cmd_i.mod_step) begin
      rem_q <= mod_digit(rem_q, x_q[BLOCK_W-1 -: DIGIT_W], units_eff);
      x_q   <= x_q << DIGIT_W;
      dig_q <= dig_q + DIG_CNT_W'(1);
    end
    if (cmd_i.save_first) begin
      first_q   <= rem_q[IDX_W-1:0];
      kfrom_q   <= (chunks_q > COUNT_W'(units_eff)) ? chunks_q - COUNT_W'(units_eff) : '0;
      x_q       <= {chunks_q, {(BLOCK_W - COUNT_W){1'b0}}} >> (CHUNK_DIGITS * DIGIT_W - COUNT_W);
      rem_q     <= '0;
      dig_q     <= '0;
      dig_lim_q <= DIG_CNT_W'(CHUNK_DIGITS - 1);
    end
    if (cmd_i.prep) begin
      prod_q <= PROD_W'(kfrom_q) * PROD_W'(chunk_q);
      maxb_q <= (start_time_q > busy_first) ? start_time_q : busy_first;
    end
    if (cmd_i.base) begin
      base_q <= maxb_q + TIME_W'(setup_q);
      k_q    <= kfrom_q;
      if (chunks_q > COUNT_W'(units_eff)) begin
        u_q <= (u_sum >= units_eff) ? IDX_W'(u_sum - units_eff) : u_sum[IDX_W-1:0];
      end else begin
        u_q <= first_q;
      end
    end
    if (cmd_i.seed) begin
      t_q <= base_q + TIME_W'(prod_q);
    end
    if (cmd_i.write) begin
      t_q <= t_q + TIME_W'(chunk_q);
      k_q <= k_q + COUNT_W'(1);
      u_q <= (u_next == units_eff) ? '0 : u_next[IDX_W-1:0];
      if (status_o.wr_last) begin
        last_q <= t_q;
      end
    end
  end

  // Busy-time memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_q[u_q] <= wr_value;
    end
    if (cmd_i.save_first) begin
      rd_data_q <= mem_q[rem_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        vld_q[u_q] <= 1'b1;
      end
      if (cmd_i.save_first) begin
        rd_vld_q <= vld_q[rem_q[IDX_W-1:0]];
      end
    end
  end

  // Output register.
  always_comb begin
    case (func_q)
      FUNC_FLUSH:             result = start_time_q;
      FUNC_READ, FUNC_WRITE:  result = last_q;
      default:                result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_data_q <= result;
    end
  end

  assign rsp_valid_o       = rsp_valid_q;
  assign completion_time_o = rsp_data_q;

  assign status_o.rw_req   = (func_i == FUNC_READ) || (func_i == FUNC_WRITE);
  assign status_o.dig_last = (dig_q == dig_lim_q);
  assign status_o.wr_last  = (k_q == chunks_q - COUNT_W'(1));
  assign status_o.out_free = !rsp_valid_q || rsp_ready_i;

endmodule

[rtl/io_unit_completion_timer_top.sv]
// ----------------------------------------------------------------------------
// io_unit_completion_timer_top
// Completion-time model for a storage device striped over parallel I/O units.
// ----------------------------------------------------------------------------
// One command is in work at a time. A flush or an unknown command goes straight
// from its transfer to the output stage. A read or write first passes the
// remainder unit, which resolves four bits per cycle, sixteen digits for the
// starting unit and five for the chunk count, and the busy-time memory then
// takes one unit update per cycle for min(chunks, units) units through its
// single write port. A finished result waits in an output register while the
// next command is taken. Busy times read as zero after reset through per-unit
// valid bits, so no clearing pass is needed.
module io_unit_completion_timer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ucmt_req_if.sink                         req,
  ucmt_rsp_if.source                       rsp,
  input  logic                             cfg_we_i,
  input  logic [ucmt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ucmt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ucmt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ucmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ucmt_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .func_i            (req.func),
    .start_block_i     (req.start_block),
    .block_count_i     (req.block_count),
    .start_time_i      (req.start_time),
    .cmd_i             (cmd),
    .status_o          (status),
    .rsp_valid_o       (rsp.valid),
    .rsp_ready_i       (rsp.ready),
    .completion_time_o (rsp.completion_time)
  );

endmodule

[rtl/ucmt_chk.sv]
// ----------------------------------------------------------------------------
// ucmt_chk
// Port-level checks of the completion timer, bound to its top level.
// ----------------------------------------------------------------------------
module ucmt_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i
);

  logic       req_xfer, rsp_xfer;
  logic [1:0] pend_q;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(req_xfer) - 2'(rsp_xfer);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("completion dropped before its transfer");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> !req_ready_i)
    else $error("new command taken while one is in work");

  a_rsp_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 2'd0)
    else $error("completion shown with no command outstanding");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |-> pend_q <= 2'd1)
    else $error("too many commands outstanding");

endmodule

bind io_unit_completion_timer_top ucmt_chk u_ucmt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready)
);

[tb/tb_io_unit_completion_timer_top.sv]
// ----------------------------------------------------------------------------
// tb_io_unit_completion_timer_top
// Self-checking bench for the I/O unit completion timer. A scoreboard keeps
// its own copy of the per-unit busy times and the timing registers, predicts
// the completion time of every command at its transfer, and compares each
// completion in order. A directed set and six further register settings, most
// randomized and including values beyond the legal ranges, are run under varied stalls.
// ----------------------------------------------------------------------------
module tb_io_unit_completion_timer_top;
  import ucmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN  = 2'd3;
  localparam int unsigned       SETTLE_CYCLES = 128;
  localparam int unsigned       QUIET_LIMIT   = 4000;
  localparam int unsigned       PHASE_ITEMS   = 200;

  class completion_scoreboard;
    logic [TIME_W-1:0]  busy_till [MAX_UNITS];
    logic [SHIFT_W-1:0] size_shift;
    logic [6:0]         unit_count;
    logic [DELAY_W-1:0] rd_setup, rd_step, rd_tail;
    logic [DELAY_W-1:0] wr_setup, wr_step, wr_tail;
    logic [TIME_W-1:0]  expected_completions [$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      foreach (busy_till[i]) busy_till[i] = '0;
      size_shift = 5'd12;
      unit_count = 7'd64;
      rd_setup   = '0;
      rd_step    = '0;
      rd_tail    = '0;
      wr_setup   = '0;
      wr_step    = '0;
      wr_tail    = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_UNIT_SIZE_SHIFT:   size_shift = data[SHIFT_W-1:0];
        REG_UNITS_IN_USE:      unit_count = data[6:0];
        REG_READ_SETUP_DELAY:  rd_setup   = data;
        REG_READ_CHUNK_TIME:   rd_step    = data;
        REG_READ_TAIL_TIME:    rd_tail    = data;
        REG_WRITE_SETUP_DELAY: wr_setup   = data;
        REG_WRITE_CHUNK_TIME:  wr_step    = data;
        REG_WRITE_TAIL_TIME:   wr_tail    = data;
        default: ;
      endcase
    endfunction

    function void note_command(logic [FUNC_W-1:0] func, logic [BLOCK_W-1:0] blk,
                               logic [COUNT_W-1:0] count, logic [TIME_W-1:0] t0);
      logic [63:0] setup, step, tail, units, first, bytes, usize;
      logic [63:0] chunks, tailed, base, k, kfrom, t;
      int unsigned shift;
      if (func == FUNC_FLUSH) begin
        expected_completions.push_back(t0);
        return;
      end
      if (func == FUNC_UNKNOWN) begin
        expected_completions.push_back('0);
        return;
      end
      if (func == FUNC_WRITE) begin
        setup = 64'(wr_setup);
        step  = 64'(wr_step);
        tail  = 64'(wr_tail);
      end else begin
        setup = 64'(rd_setup);
        step  = 64'(rd_step);
        tail  = 64'(rd_tail);
      end
      shift = (size_shift < BLOCK_SHIFT) ? BLOCK_SHIFT : size_shift;
      if (unit_count == 0) units = 1;
      else if (unit_count > MAX_UNITS) units = MAX_UNITS;
      else units = 64'(unit_count);
      first = (blk >> (shift - BLOCK_SHIFT)) % units;
      bytes = 64'(count) << BLOCK_SHIFT;
      usize = 64'd1 << shift;
      if (bytes == 0) begin
        chunks = 1;
        tailed = 0;
      end else begin
        chunks = (bytes + usize - 1) >> shift;
        tailed = (chunks < units) ? chunks : units;
      end
      base  = (t0 > busy_till[first]) ? t0 : busy_till[first];
      base  = base + setup;
      kfrom = (chunks > units) ? chunks - units : 0;
      for (k = kfrom; k < chunks; k++) begin
        t = base + k * step;
        if (k < tailed) t = t + tail;
        busy_till[(first + k) % units] = t;
      end
      expected_completions.push_back(base + (chunks - 1) * step);
    endfunction

    function void check_completion(logic [TIME_W-1:0] actual);
      logic [TIME_W-1:0] want;
      if (expected_completions.size() == 0) begin
        $error("completion_time: no result expected, actual %0d", actual);
        errors++;
        return;
      end
      want = expected_completions.pop_front();
      checked++;
      if (actual !== want) begin
        $error("completion_time: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ucmt_req_if req_ch ();
  ucmt_rsp_if rsp_ch ();

  completion_scoreboard sb = new();

  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 78;
  int unsigned quiet_cycles  = 0;
  int unsigned settings_seen = 0;
  int unsigned func_seen [4] = '{0, 0, 0, 0};
  logic [TIME_W-1:0] clock_ns = '0;

  io_unit_completion_timer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_completion(rsp_ch.completion_time);
      if (req_ch.valid && req_ch.ready) begin
        sb.note_command(req_ch.func, req_ch.start_block, req_ch.block_count,
                        req_ch.start_time);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (req_ch.valid && req_ch.ready) ||
        (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_io_unit_completion_timer_top: errors");
      $finish;
    end
  end

  task automatic configure(logic [4:0] shift, logic [6:0] units,
                           logic [31:0] rs, logic [31:0] rc, logic [31:0] rt,
                           logic [31:0] ws, logic [31:0] wc, logic [31:0] wt);
    cfg_reg_e    regs [8];
    logic [31:0] vals [8];
    regs = '{REG_UNIT_SIZE_SHIFT, REG_UNITS_IN_USE, REG_READ_SETUP_DELAY,
             REG_READ_CHUNK_TIME, REG_READ_TAIL_TIME, REG_WRITE_SETUP_DELAY,
             REG_WRITE_CHUNK_TIME, REG_WRITE_TAIL_TIME};
    vals = '{32'(shift), 32'(units), rs, rc, rt, ws, wc, wt};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  task automatic send_cmd(logic [FUNC_W-1:0] func, logic [BLOCK_W-1:0] blk,
                          logic [COUNT_W-1:0] count, logic [TIME_W-1:0] t0);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= func;
    req_ch.start_block <= blk;
    req_ch.block_count <= count;
    req_ch.start_time  <= t0;
    func_seen[func]++;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stop sending and wait until every predicted completion has been checked.
  task automatic drain(int unsigned settle);
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_completions.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned n_items);
    logic [FUNC_W-1:0]  func;
    logic [BLOCK_W-1:0] blk;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  t0;
    int unsigned        r;
    for (int unsigned i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 40) func = FUNC_READ;
      else if (r < 80) func = FUNC_WRITE;
      else if (r < 90) func = FUNC_FLUSH;
      else func = FUNC_UNKNOWN;
      blk = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom_range(65535));
      r = $urandom_range(99);
      if (r < 40) count = COUNT_W'($urandom_range(64, 1));
      else if (r < 70) count = COUNT_W'($urandom_range(4096, 1));
      else if (r < 92) count = COUNT_W'($urandom_range(131071, 0));
      else if (r < 95) count = '0;
      else if (r < 98) count = 17'd65536;
      else count = '1;
      clock_ns = clock_ns + $urandom_range(400);
      r = $urandom_range(99);
      if (r < 85) t0 = clock_ns;
      else if (r < 93) t0 = {$urandom, $urandom};
      else t0 = {32'hFFFF_FFFF, $urandom};
      send_cmd(func, blk, count, t0);
      if (i % 97 == 96) drain(0);
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_UNIT_SIZE_SHIFT;
    cfg_data_i         = '0;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_READ;
    req_ch.start_block = '0;
    req_ch.block_count = '0;
    req_ch.start_time  = '0;
    rsp_ch.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: busy times start at zero, all timing registers zero.
    send_cmd(FUNC_READ, 64'd8, 17'd8, 64'd500);
    send_cmd(FUNC_WRITE, 64'd0, 17'd1, 64'd0);
    drain(SETTLE_CYCLES);

    configure(5'd9, 7'd4, 32'd100, 32'd10, 32'd5, 32'd200, 32'd20, 32'd7);
    send_cmd(FUNC_READ, 64'd0, 17'd1, 64'd1000);
    send_cmd(FUNC_WRITE, 64'd1, 17'd4, 64'd1000);
    send_cmd(FUNC_READ, 64'd2, 17'd10, 64'd0);
    send_cmd(FUNC_FLUSH, 64'd5, 17'd3, 64'd12345);
    send_cmd(FUNC_UNKNOWN, '1, '1, '1);
    send_cmd(FUNC_READ, 64'd3, 17'd0, 64'd2000);
    send_cmd(FUNC_WRITE, '1, 17'd65536, 64'hFFFF_FFFF_FFFF_FFCE);
    send_cmd(FUNC_READ, '1, '1, 64'd0);
    send_cmd(FUNC_WRITE, 64'd0, 17'd1, '1);
    send_cmd(FUNC_FLUSH, '1, '1, 64'd0);
    send_cmd(FUNC_FLUSH, 64'd0, 17'd0, '1);
    send_cmd(FUNC_UNKNOWN, 64'd0, 17'd0, 64'd0);
    drain(SETTLE_CYCLES);

    configure(5'd9, 7'd1, '1, '1, '1, '1, '1, '1);
    run_phase(PHASE_ITEMS);
    drain(SETTLE_CYCLES);
    configure(5'd20, 7'd64, $urandom_range(5000), $urandom_range(500),
              $urandom_range(300), $urandom_range(5000), $urandom_range(500),
              $urandom_range(300));
    run_phase(PHASE_ITEMS);
    drain(SETTLE_CYCLES);

    send_idle_pct = 78;
    recv_idle_pct = 20;
    configure(5'd0, 7'd0, $urandom_range(2000), $urandom_range(200),
              $urandom_range(100), $urandom_range(2000), $urandom_range(200),
              $urandom_range(100));
    run_phase(PHASE_ITEMS);
    drain(SETTLE_CYCLES);
    configure(5'd31, 7'd127, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_phase(PHASE_ITEMS);
    drain(SETTLE_CYCLES);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(5'($urandom_range(20, 9)), 7'($urandom_range(64, 1)), '0, '0, '0, '0, '0, '0);
    run_phase(PHASE_ITEMS);
    drain(SETTLE_CYCLES);
    configure(5'($urandom_range(31)), 7'($urandom_range(127)), $urandom_range(3000),
              $urandom_range(300), $urandom_range(300), $urandom_range(3000),
              $urandom_range(300), $urandom_range(300));
    run_phase(PHASE_ITEMS);
    drain(SETTLE_CYCLES);

    sb.errors = sb.errors + sb.expected_completions.size();
    $display("Checked %0d completions: %0d reads, %0d writes, %0d flushes, %0d unknown.",
             sb.checked, func_seen[FUNC_READ], func_seen[FUNC_WRITE],
             func_seen[FUNC_FLUSH], func_seen[FUNC_UNKNOWN]);
    $display("Ran %0d register settings, unit size and count out of range included.",
             settings_seen);
    if (sb.errors == 0) begin
      $display("tb_io_unit_completion_timer_top: clean");
    end else begin
      $display("tb_io_unit_completion_timer_top: errors");
    end
    $finish;
  end

endmodule
